// File: rtl/core/gpdt_pkg.sv
// gpdt_pkg: shared constants, codes and types of the pin pulse and debounce table
// no dependencies; compiled first, used by every other file of the block
`default_nettype none

package gpdt_pkg;

   // table and pin sizing
   localparam int TABLE_DEPTH = 16;
   localparam int PIN_TOTAL   = 40;

   // fixed field widths
   localparam int CMD_W     = 3;
   localparam int PIN_W     = 6;
   localparam int TIME_W    = 32;
   localparam int LEVELS_W  = 40;
   localparam int KIND_W    = 2;
   localparam int ENTRIES_W = 5;
   localparam int DEB_W     = 16;

   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

   // derived sizes
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int UNRES_COUNT = 17;
   localparam int UNRES_IDX_W = $clog2(UNRES_COUNT);
   localparam int UNRES_CNT_W = $clog2(UNRES_COUNT + 1);
   localparam int WALK_W      = (CNT_W > UNRES_CNT_W) ? CNT_W : UNRES_CNT_W;
   localparam int PIN_LIMIT   = (PIN_TOTAL < LEVELS_W) ? PIN_TOTAL : LEVELS_W;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_SET_OUT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_IN   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ALL_LOW  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ALL_HIGH = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_DRIVE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REVERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PRESS  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      OP_SET_OUT,
      OP_SET_IN,
      OP_TICK,
      OP_ALL_LOW,
      OP_ALL_HIGH
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FIND,
      BK_TICK_REV,
      BK_TICK_BTN,
      BK_ALL,
      BK_FINISH
   } back_state_type;

   // classified command as it sits in the queue
   typedef struct packed {
      op_type                op;
      logic [PIN_W-1:0]      pin;
      logic                  level;
      logic [TIME_W-1:0]     interval;
      logic [LEVELS_W-1:0]   levels;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic rev;
      logic inp;
      logic last;
      logic stable;
   } flags_type;

   localparam flags_type FLAGS_FRESH = '{rev: 1'b0, inp: 1'b0, last: 1'b1, stable: 1'b1};

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [PIN_W-1:0]     pin;
      logic                 level;
      logic [ENTRIES_W-1:0] entries;
   } result_type;

   // unreserved pins in ascending order, driven by all-low and all-high
   function automatic logic [PIN_W-1:0] unres_pin(input logic [UNRES_IDX_W-1:0] idx);
      logic [PIN_W-1:0] p;
      case (idx)
         5'd0:    p = 6'd0;
         5'd1:    p = 6'd1;
         5'd2:    p = 6'd2;
         5'd3:    p = 6'd3;
         5'd4:    p = 6'd4;
         5'd5:    p = 6'd5;
         5'd6:    p = 6'd16;
         5'd7:    p = 6'd17;
         5'd8:    p = 6'd18;
         5'd9:    p = 6'd19;
         5'd10:   p = 6'd21;
         5'd11:   p = 6'd22;
         5'd12:   p = 6'd23;
         5'd13:   p = 6'd25;
         5'd14:   p = 6'd26;
         5'd15:   p = 6'd27;
         5'd16:   p = 6'd33;
         default: p = 6'd0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/gpdt_ifs.sv
// gpdt_ifs: valid/ready channel interfaces for request, response and csr write
// depends on gpdt_pkg for field widths
`default_nettype none

interface gpdt_req_if import gpdt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [PIN_W-1:0]    pin;
   logic                level;
   logic [TIME_W-1:0]   interval_ms;
   logic [LEVELS_W-1:0] pin_levels;

   modport source (output valid, cmd, pin, level, interval_ms, pin_levels, input ready);
   modport sink   (input valid, cmd, pin, level, interval_ms, pin_levels, output ready);
endinterface

interface gpdt_rsp_if import gpdt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [PIN_W-1:0]     pin_out;
   logic                 drive_level;
   logic [ENTRIES_W-1:0] entries_used;
   logic                 last;

   modport source (output valid, kind, pin_out, drive_level, entries_used, last, input ready);
   modport sink   (input valid, kind, pin_out, drive_level, entries_used, last, output ready);
endinterface

interface gpdt_csr_if import gpdt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DEB_W-1:0] debounce_ms;

   modport source (output valid, debounce_ms, input ready);
   modport sink   (input valid, debounce_ms, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gpdt_front.sv
// gpdt_front: accepts request items, classifies the command, queues it for the back end
// depends on gpdt_pkg and gpdt_req_if
`default_nettype none

module gpdt_front import gpdt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   gpdt_req_if.sink       req,
   output queue_head_type q_head,
   input  logic           q_pop
);

   item_type            queue_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   q_count_ff, q_count_in;
   item_type            new_item;
   logic                keep;
   logic                push;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // classify; unused command codes are taken and dropped here
   always_comb begin
      keep = 1'b1;
      new_item.op = OP_SET_OUT;
      case (req.cmd)
         CMD_SET_OUT:  new_item.op = OP_SET_OUT;
         CMD_SET_IN:   new_item.op = OP_SET_IN;
         CMD_TICK:     new_item.op = OP_TICK;
         CMD_ALL_LOW:  new_item.op = OP_ALL_LOW;
         CMD_ALL_HIGH: new_item.op = OP_ALL_HIGH;
         default:      keep = 1'b0;
      endcase
      new_item.pin      = req.pin;
      new_item.level    = req.level;
      new_item.interval = req.interval_ms;
      new_item.levels   = req.pin_levels;
   end

   assign req.ready = (q_count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready && keep;

   assign q_head.valid = (q_count_ff != '0);
   assign q_head.item  = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = q_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      q_count_in = q_count_ff;
      if (push && !q_pop) begin
         q_count_in = q_count_ff + 1'b1;
      end else if (!push && q_pop) begin
         q_count_in = q_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/gpdt_back.sv
// gpdt_back: pin table, millisecond clock, sequencer that walks the table and output register
// depends on gpdt_pkg, gpdt_rsp_if and gpdt_csr_if
`default_nettype none

module gpdt_back import gpdt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type q_head,
   output logic           q_pop,
   gpdt_rsp_if.source     rsp,
   gpdt_csr_if.sink       csr
);

   // pin table
   logic [PIN_W-1:0]  tab_pin      [TABLE_DEPTH];
   logic [TIME_W-1:0] tab_interval [TABLE_DEPTH];
   logic [TIME_W-1:0] tab_set_time [TABLE_DEPTH];
   logic [TIME_W-1:0] tab_deb_time [TABLE_DEPTH];
   flags_type         tab_flags    [TABLE_DEPTH];

   back_state_type     state_ff, state_in;
   logic [WALK_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TIME_W-1:0]  clock_ms_ff, clock_ms_in;
   logic [DEB_W-1:0]   debounce_ff;
   item_type           cur_ff, cur_in;
   result_type         hold_ff, hold_in;
   logic               hold_valid_ff, hold_valid_in;
   result_type         rsp_res_ff;
   logic               rsp_last_ff;
   logic               rsp_valid_ff;

   logic [IDX_W-1:0]   tab_idx;
   logic [PIN_W-1:0]   rd_pin;
   logic [TIME_W-1:0]  rd_interval, rd_set_time, rd_deb_time;
   flags_type          rd_flags;

   logic               tab_wr;
   logic [PIN_W-1:0]   wr_pin;
   logic [TIME_W-1:0]  wr_interval, wr_set_time, wr_deb_time;
   flags_type          wr_flags, base_flags;

   logic               in_range, do_apply, added;
   logic               emit, finish, push, push_last, out_free, advance, q_pop_raw;
   result_type         emit_res;
   logic [TIME_W-1:0]  since_set, since_deb;
   logic               sample;

   assign tab_idx     = idx_ff[IDX_W-1:0];
   assign rd_pin      = tab_pin[tab_idx];
   assign rd_interval = tab_interval[tab_idx];
   assign rd_set_time = tab_set_time[tab_idx];
   assign rd_deb_time = tab_deb_time[tab_idx];
   assign rd_flags    = tab_flags[tab_idx];

   assign in_range  = idx_ff < WALK_W'(count_ff);
   assign since_set = clock_ms_ff - rd_set_time;
   assign since_deb = clock_ms_ff - rd_deb_time;
   // pins past the sampled range read as idle high
   assign sample    = (rd_pin < PIN_W'(PIN_LIMIT)) ? cur_ff.levels[rd_pin] : 1'b1;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      clock_ms_in = clock_ms_ff;
      cur_in      = cur_ff;
      q_pop_raw   = 1'b0;
      tab_wr      = 1'b0;
      wr_pin      = rd_pin;
      wr_interval = rd_interval;
      wr_set_time = rd_set_time;
      wr_deb_time = rd_deb_time;
      wr_flags    = rd_flags;
      base_flags  = rd_flags;
      do_apply    = 1'b0;
      added       = 1'b0;
      emit        = 1'b0;
      emit_res    = '0;
      finish      = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (q_head.valid) begin
               q_pop_raw = 1'b1;
               cur_in    = q_head.item;
               idx_in    = '0;
               case (q_head.item.op)
                  OP_SET_OUT, OP_SET_IN: state_in = BK_FIND;
                  OP_TICK: begin
                     clock_ms_in = clock_ms_ff + 1'b1;
                     state_in    = BK_TICK_REV;
                  end
                  OP_ALL_LOW, OP_ALL_HIGH: state_in = BK_ALL;
                  default: state_in = BK_IDLE;
               endcase
            end
         end

         BK_FIND: begin
            if (in_range) begin
               if (rd_pin == cur_ff.pin) begin
                  do_apply = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
               // full table, set dropped
               state_in = BK_FINISH;
            end else begin
               do_apply = 1'b1;
               added    = 1'b1;
               count_in = count_ff + 1'b1;
            end

            if (do_apply) begin
               tab_wr   = 1'b1;
               state_in = BK_FINISH;
               if (added) begin
                  base_flags  = FLAGS_FRESH;
                  wr_pin      = cur_ff.pin;
                  wr_interval = '0;
                  wr_set_time = '0;
                  wr_deb_time = '0;
               end
               wr_flags = base_flags;
               if (cur_ff.op == OP_SET_OUT) begin
                  wr_interval  = cur_ff.interval;
                  wr_set_time  = clock_ms_ff;
                  wr_flags.rev = 1'b0;
                  emit         = 1'b1;
                  emit_res     = '{kind: KIND_DRIVE, pin: cur_ff.pin, level: cur_ff.level,
                                   entries: ENTRIES_W'(count_in)};
               end else begin
                  wr_flags.inp    = 1'b1;
                  wr_flags.last   = 1'b1;
                  wr_flags.stable = 1'b1;
                  wr_deb_time     = '0;
               end
            end
         end

         BK_TICK_REV: begin
            if (in_range) begin
               idx_in = idx_ff + 1'b1;
               if ((rd_interval != '0) && (since_set >= rd_interval) && !rd_flags.rev) begin
                  tab_wr       = 1'b1;
                  wr_flags.rev = 1'b1;
                  emit         = 1'b1;
                  emit_res     = '{kind: KIND_REVERT, pin: rd_pin, level: 1'b0,
                                   entries: ENTRIES_W'(count_ff)};
               end
            end else begin
               idx_in   = '0;
               state_in = BK_TICK_BTN;
            end
         end

         BK_TICK_BTN: begin
            if (in_range) begin
               idx_in = idx_ff + 1'b1;
               if (rd_flags.inp) begin
                  tab_wr = 1'b1;
                  if (sample != rd_flags.last) begin
                     wr_deb_time = clock_ms_ff;
                  end else if ((since_deb > TIME_W'(debounce_ff)) &&
                               (sample != rd_flags.stable)) begin
                     wr_flags.stable = sample;
                     if (!sample) begin
                        emit     = 1'b1;
                        emit_res = '{kind: KIND_PRESS, pin: rd_pin, level: 1'b0,
                                     entries: ENTRIES_W'(count_ff)};
                     end
                  end
                  wr_flags.last = sample;
               end
            end else begin
               state_in = BK_FINISH;
            end
         end

         BK_ALL: begin
            if (idx_ff < WALK_W'(UNRES_COUNT)) begin
               idx_in   = idx_ff + 1'b1;
               emit     = 1'b1;
               emit_res = '{kind: KIND_DRIVE, pin: unres_pin(idx_ff[UNRES_IDX_W-1:0]),
                            level: (cur_ff.op == OP_ALL_HIGH), entries: ENTRIES_W'(count_ff)};
            end else begin
               state_in = BK_FINISH;
            end
         end

         BK_FINISH: begin
            finish   = 1'b1;
            state_in = BK_IDLE;
         end

         default: state_in = BK_IDLE;
      endcase
   end

   // one result is held back so the final one can carry last
   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      push          = 1'b0;
      push_last     = 1'b0;
      if (emit) begin
         push          = hold_valid_ff;
         hold_in       = emit_res;
         hold_valid_in = 1'b1;
      end
      if (finish && hold_valid_ff) begin
         push          = 1'b1;
         push_last     = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   assign advance = !push || out_free;
   assign q_pop   = q_pop_raw && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         idx_ff        <= '0;
         count_ff      <= '0;
         clock_ms_ff   <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         debounce_ff   <= DEBOUNCE_RESET;
      end else begin
         if (advance) begin
            state_ff      <= state_in;
            idx_ff        <= idx_in;
            count_ff      <= count_in;
            clock_ms_ff   <= clock_ms_in;
            hold_valid_ff <= hold_valid_in;
         end
         if (push && advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr.valid) begin
            debounce_ff <= csr.debounce_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cur_ff  <= cur_in;
         hold_ff <= hold_in;
      end
      if (push && advance) begin
         rsp_res_ff  <= hold_ff;
         rsp_last_ff <= push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (tab_wr && advance) begin
         tab_pin[tab_idx]      <= wr_pin;
         tab_interval[tab_idx] <= wr_interval;
         tab_set_time[tab_idx] <= wr_set_time;
         tab_deb_time[tab_idx] <= wr_deb_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            tab_flags[i] <= FLAGS_FRESH;
         end
      end else if (tab_wr && advance) begin
         tab_flags[tab_idx] <= wr_flags;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = rsp_res_ff.kind;
   assign rsp.pin_out      = rsp_res_ff.pin;
   assign rsp.drive_level  = rsp_res_ff.level;
   assign rsp.entries_used = rsp_res_ff.entries;
   assign rsp.last         = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/core/gpio_pulse_debounce_table_unit.sv
// gpio_pulse_debounce_table_unit: top level of the pin pulse and button debounce table
// depends on gpdt_pkg, gpdt_ifs, gpdt_front and gpdt_back
//
// usage
// - req_chan carries one command item: set output, set input, millisecond tick,
//   all low or all high, with pin, level, interval_ms and the sampled pin_levels
// - rsp_chan returns the result items of each command in order; last marks the
//   final one, commands without results return nothing
// - csr_chan writes debounce_ms; it is always ready, write it only while idle
// - in the back end set commands search the table for their pin, ticks walk
//   the table twice (reverts, then buttons), all low / all high walk the
//   unreserved pins; the sequencer takes one entry per cycle unless the output stalls
// - one result can leave per cycle during a walk while the receiver is ready;
//   each result passes the hold register and then the output register
// - a two-entry command queue sits between the front and the back, so new items
//   are taken while the back end walks the table
// - reset clears the table count, the millisecond clock, the queue and all
//   valids, and loads debounce_ms with 50; table contents need no clearing pass
// - when the receiver stalls, the output register holds its item and the
//   sequencer waits once it has a result to pass; the queue takes items until full
`default_nettype none

module gpio_pulse_debounce_table_unit import gpdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   gpdt_req_if.sink   req_chan,
   gpdt_rsp_if.source rsp_chan,
   gpdt_csr_if.sink   csr_chan
);

   // head of the command queue and its pop strobe
   queue_head_type q_head;
   logic           q_pop;

   // front end: take and classify items, queue them
   gpdt_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   // back end: table, clock, sequencer and result register
   gpdt_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_head (q_head),
      .q_pop  (q_pop),
      .rsp    (rsp_chan),
      .csr    (csr_chan)
   );

endmodule

`default_nettype wire

// File: rtl/core/gpdt_checker.sv
// gpdt_checker: port level assertions for the pin pulse and debounce table
// depends on gpdt_pkg; bound to gpio_pulse_debounce_table_unit
`default_nettype none

module gpdt_checker import gpdt_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [KIND_W-1:0]    rsp_kind,
   input logic [PIN_W-1:0]     rsp_pin_out,
   input logic                 rsp_drive_level,
   input logic [ENTRIES_W-1:0] rsp_entries_used,
   input logic                 rsp_last
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_kind, rsp_pin_out, rsp_drive_level,
                                            rsp_entries_used, rsp_last}))
      else $error("result payload changed while stalled");

   // reverts and presses always report low
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_DRIVE) |-> !rsp_drive_level)
      else $error("revert or press with high level");

   // no result with the unused kind code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind != KIND_UNUSED))
      else $error("result with unused kind");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind gpio_pulse_debounce_table_unit gpdt_checker u_gpdt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_kind         (rsp_chan.kind),
   .rsp_pin_out      (rsp_chan.pin_out),
   .rsp_drive_level  (rsp_chan.drive_level),
   .rsp_entries_used (rsp_chan.entries_used),
   .rsp_last         (rsp_chan.last)
);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for gpio_pulse_debounce_table_unit (pin pulse and debounce table)
// needs gpdt_pkg, gpdt_ifs and the unit's rtl; predicts every result item and checks in order

module tb;
   import gpdt_pkg::*;

   // spare command codes that the unit ignores
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 77;
   // a tick on a full table walks it twice, and two more items can sit queued
   localparam int SETTLE_CYCLES   = 150;
   localparam int LIMIT_NS        = 5_000_000;

   // the sixteen pins that end up in the table: extremes, beyond-range and ordinary pins
   localparam int TABLE_PINS [16] = '{0, 63, 39, 40, 1, 2, 3, 4, 16, 17, 21, 25, 33, 38, 50, 12};

   // per-phase debounce setting and idle percentages
   localparam int PHASE_DEBOUNCE [PHASES] = '{0, 3, 65535, 2, 1};
   localparam int PHASE_SEND_IDLE [PHASES] = '{0, 65, 0, 17, 0};
   localparam int PHASE_RECV_STALL [PHASES] = '{0, 0, 65, 17, 0};

   // one command item waiting to go out; hold makes the sender wait for all results first
   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [PIN_W-1:0]    pin;
      logic                level;
      logic [TIME_W-1:0]   interval;
      logic [LEVELS_W-1:0] levels;
      logic                hold;
   } gpio_cmd_type;

   // one result item as the unit should return it
   typedef struct {
      logic [KIND_W-1:0]    kind;
      logic [PIN_W-1:0]     pin;
      logic                 level;
      logic [ENTRIES_W-1:0] entries;
      logic                 last;
   } pin_event_type;

   logic clock;
   logic reset;

   gpdt_req_if req_if ();
   gpdt_rsp_if rsp_if ();
   gpdt_csr_if csr_if ();

   gpio_pulse_debounce_table_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // ---------------------------------------------------------------------------
   // predicted copy of the unit's table, clock and register
   // ---------------------------------------------------------------------------
   int unsigned          tbl_count;
   logic [TIME_W-1:0]    ms_now;
   logic [DEB_W-1:0]     debounce_now;
   logic [PIN_W-1:0]     tbl_pin       [TABLE_DEPTH];
   logic [TIME_W-1:0]    tbl_interval  [TABLE_DEPTH];
   logic [TIME_W-1:0]    tbl_armed_at  [TABLE_DEPTH];
   logic [TIME_W-1:0]    tbl_settle_at [TABLE_DEPTH];
   flags_type            tbl_flags     [TABLE_DEPTH];

   gpio_cmd_type  cmd_backlog [$];     // items the driver still has to send
   pin_event_type pin_events_due [$];  // results predicted but not yet seen
   pin_event_type oldest_due;

   int send_idle;
   int recv_stall;
   int items_taken;
   int results_seen;
   int drives_seen;
   int reverts_seen;
   int presses_seen;
   int fail_count;

   // find a pin's entry, appending it when new; -1 when the table is full
   function automatic int claim_entry(input logic [PIN_W-1:0] p);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_pin[i] == p)
            return i;
      if (tbl_count >= TABLE_DEPTH)
         return -1;
      tbl_pin[tbl_count]       = p;
      tbl_flags[tbl_count]     = FLAGS_FRESH;
      tbl_interval[tbl_count]  = '0;
      tbl_armed_at[tbl_count]  = '0;
      tbl_settle_at[tbl_count] = '0;
      tbl_count++;
      return tbl_count - 1;
   endfunction

   function automatic pin_event_type pin_event(input logic [KIND_W-1:0] k,
                                               input logic [PIN_W-1:0] p, input logic lv);
      pin_event_type ev;
      ev.kind    = k;
      ev.pin     = p;
      ev.level   = lv;
      ev.entries = ENTRIES_W'(tbl_count);
      ev.last    = 1'b0;
      return ev;
   endfunction

   // pins driven by all-low and all-high: everything not reserved by the board
   function automatic bit pin_is_free(input int p);
      return (p <= 5) || (p >= 16 && p <= 19) || (p >= 21 && p <= 23) ||
             (p >= 25 && p <= 27) || (p == 33);
   endfunction

   // advance the predicted state by one accepted command and queue its results
   function automatic void forecast_results(input logic [CMD_W-1:0] c,
                                            input logic [PIN_W-1:0] p,
                                            input logic lv,
                                            input logic [TIME_W-1:0] ivl,
                                            input logic [LEVELS_W-1:0] lvls);
      pin_event_type evs [$];
      int         e;
      logic       rd;
      flags_type  f;
      case (c)
         CMD_SET_OUT: begin
            e = claim_entry(p);
            if (e >= 0) begin
               tbl_interval[e]  = ivl;
               tbl_armed_at[e]  = ms_now;
               tbl_flags[e].rev = 1'b0;
               evs.push_back(pin_event(KIND_DRIVE, p, lv));
            end
         end
         CMD_SET_IN: begin
            e = claim_entry(p);
            if (e >= 0) begin
               tbl_flags[e].inp    = 1'b1;
               tbl_flags[e].last   = 1'b1;
               tbl_flags[e].stable = 1'b1;
               tbl_settle_at[e]    = '0;
            end
         end
         CMD_TICK: begin
            ms_now = ms_now + 1;
            // one-shot reverts first, in table order
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_interval[i] != 0 && (ms_now - tbl_armed_at[i]) >= tbl_interval[i] &&
                   !tbl_flags[i].rev) begin
                  tbl_flags[i].rev = 1'b1;
                  evs.push_back(pin_event(KIND_REVERT, tbl_pin[i], 1'b0));
               end
            end
            // then the buttons; pins past the sampled range read as idle high
            for (int i = 0; i < tbl_count; i++) begin
               f = tbl_flags[i];
               if (f.inp) begin
                  rd = (tbl_pin[i] < PIN_TOTAL) ? lvls[tbl_pin[i]] : 1'b1;
                  if (rd != f.last)
                     tbl_settle_at[i] = ms_now;
                  if ((ms_now - tbl_settle_at[i]) > TIME_W'(debounce_now) && rd != f.stable) begin
                     f.stable = rd;
                     if (!rd)
                        evs.push_back(pin_event(KIND_PRESS, tbl_pin[i], 1'b0));
                  end
                  f.last       = rd;
                  tbl_flags[i] = f;
               end
            end
         end
         CMD_ALL_LOW, CMD_ALL_HIGH: begin
            for (int i = 0; i < PIN_TOTAL; i++)
               if (pin_is_free(i))
                  evs.push_back(pin_event(KIND_DRIVE, PIN_W'(i), c == CMD_ALL_HIGH));
         end
         default: ;
      endcase
      if (evs.size() != 0)
         evs[evs.size() - 1].last = 1'b1;
      foreach (evs[i])
         pin_events_due.push_back(evs[i]);
   endfunction

   function automatic void queue_item(input logic [CMD_W-1:0] c, input logic [PIN_W-1:0] p,
                                      input logic lv, input logic [TIME_W-1:0] ivl,
                                      input logic [LEVELS_W-1:0] lvls);
      gpio_cmd_type it;
      it.cmd      = c;
      it.pin      = p;
      it.level    = lv;
      it.interval = ivl;
      it.levels   = lvls;
      it.hold     = 1'b0;
      cmd_backlog.push_back(it);
   endfunction

   function automatic void log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%s", msg);
   endfunction

   // ---------------------------------------------------------------------------
   // clock and initial values of every unit input
   // ---------------------------------------------------------------------------
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.cmd         = CMD_TICK;
      req_if.pin         = '0;
      req_if.level       = 1'b0;
      req_if.interval_ms = '0;
      req_if.pin_levels  = '1;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.debounce_ms = '0;
   end

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // driver: feeds the request channel from the backlog
   // predicts each item at the edge where it is taken
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            forecast_results(req_if.cmd, req_if.pin, req_if.level, req_if.interval_ms,
                             req_if.pin_levels);
            items_taken++;
         end
         // a held item waits until every predicted result has come back
         if (cmd_backlog.size() != 0 && !(cmd_backlog[0].hold && pin_events_due.size() != 0) &&
             $urandom_range(0, 99) >= send_idle) begin
            req_if.cmd         <= cmd_backlog[0].cmd;
            req_if.pin         <= cmd_backlog[0].pin;
            req_if.level       <= cmd_backlog[0].level;
            req_if.interval_ms <= cmd_backlog[0].interval;
            req_if.pin_levels  <= cmd_backlog[0].levels;
            req_if.valid       <= 1'b1;
            void'(cmd_backlog.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: random back-pressure, each result checked against the oldest prediction
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         case (rsp_if.kind)
            KIND_DRIVE:  drives_seen++;
            KIND_REVERT: reverts_seen++;
            KIND_PRESS:  presses_seen++;
            default: ;
         endcase
         if (pin_events_due.size() == 0) begin
            log_failure($sformatf("%0t: unexpected result kind %0d pin %0d level %0d used %0d last %0d",
                                  $time, rsp_if.kind, rsp_if.pin_out, rsp_if.drive_level,
                                  rsp_if.entries_used, rsp_if.last));
         end else begin
            oldest_due = pin_events_due.pop_front();
            if (rsp_if.kind !== oldest_due.kind || rsp_if.pin_out !== oldest_due.pin ||
                rsp_if.drive_level !== oldest_due.level ||
                rsp_if.entries_used !== oldest_due.entries || rsp_if.last !== oldest_due.last)
               log_failure($sformatf({"%0t: mismatch, expected kind %0d pin %0d level %0d used %0d",
                                      " last %0d, got kind %0d pin %0d level %0d used %0d last %0d"},
                                     $time, oldest_due.kind, oldest_due.pin, oldest_due.level,
                                     oldest_due.entries, oldest_due.last, rsp_if.kind,
                                     rsp_if.pin_out, rsp_if.drive_level, rsp_if.entries_used,
                                     rsp_if.last));
         end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall);
   end

   // one debounce write; the unit takes it at the edge with valid and ready high
   task automatic write_debounce(input logic [DEB_W-1:0] v);
      @(posedge clock);
      csr_if.valid       <= 1'b1;
      csr_if.debounce_ms <= v;
      do
         @(posedge clock);
      while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
      debounce_now = v;
   endtask

   // backlog sent, every result back, then time for result-free items still in the walk
   task automatic wait_quiet();
      while (cmd_backlog.size() != 0 || req_if.valid)
         @(posedge clock);
      while (pin_events_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // stimulus and phase control
   // ---------------------------------------------------------------------------
   initial begin
      gpio_cmd_type      it;
      logic [LEVELS_W-1:0] lv_state;
      int                sel;
      int                r;
      int                flip;
      int                counted;

      tbl_count    = 0;
      ms_now       = '0;
      debounce_now = DEBOUNCE_RESET;
      send_idle    = 0;
      recv_stall   = 0;
      items_taken  = 0;
      results_seen = 0;
      drives_seen  = 0;
      reverts_seen = 0;
      presses_seen = 0;
      fail_count   = 0;
      lv_state     = '1;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part, short debounce so presses show up quickly
      write_debounce(16'd1);
      queue_item(CMD_SET_OUT, 6'd0, 1'b1, 32'd2, '1);
      queue_item(CMD_SET_OUT, 6'd63, 1'b0, 32'hFFFF_FFFF, '0);
      queue_item(CMD_SET_IN, 6'd39, 1'b0, '0, '0);
      // beyond the sampled range: stored, but always reads high
      queue_item(CMD_SET_IN, 6'd40, 1'b1, '1, '1);
      // an input entry also driven as output, reverts on the first tick
      queue_item(CMD_SET_OUT, 6'd39, 1'b1, 32'd1, '0);
      queue_item(CMD_TICK, 6'd0, 1'b0, '0, '1);
      // pin 39 held low long enough for a press, then released
      queue_item(CMD_TICK, 6'd63, 1'b1, '1, '0);
      queue_item(CMD_TICK, 6'd0, 1'b0, '0, '0);
      queue_item(CMD_TICK, 6'd0, 1'b0, '0, '0);
      queue_item(CMD_TICK, 6'd0, 1'b0, '0, '1);
      queue_item(CMD_SPARE_FIRST, 6'd5, 1'b1, 32'd7, '1);
      queue_item(CMD_ALL_LOW, 6'd0, 1'b0, '0, '0);
      queue_item(CMD_ALL_HIGH, 6'd0, 1'b0, '0, '0);
      // rearm an existing entry
      queue_item(CMD_SET_OUT, 6'd63, 1'b1, 32'd3, '0);
      // fill the table, alternating buttons and timed outputs
      for (int k = 4; k < 16; k++) begin
         if (k % 2)
            queue_item(CMD_SET_IN, PIN_W'(TABLE_PINS[k]), 1'b0, '0, '0);
         else
            queue_item(CMD_SET_OUT, PIN_W'(TABLE_PINS[k]), k % 4 == 0, TIME_W'(k), '0);
      end
      // table full: new pins are dropped without a result
      queue_item(CMD_SET_OUT, 6'd8, 1'b1, 32'd5, '0);
      queue_item(CMD_SET_IN, 6'd9, 1'b0, '0, '0);
      wait_quiet();

      // random phases, each with its own debounce and idling mix
      for (int ph = 0; ph < PHASES; ph++) begin
         write_debounce(DEB_W'(PHASE_DEBOUNCE[ph]));
         send_idle  = PHASE_SEND_IDLE[ph];
         recv_stall = PHASE_RECV_STALL[ph];
         counted    = 0;
         while (counted < ITEMS_PER_PHASE) begin
            // unused fields still carry random bits
            it.pin      = PIN_W'($urandom);
            it.level    = 1'($urandom);
            it.interval = $urandom;
            it.levels   = LEVELS_W'({$urandom, $urandom});
            it.hold     = (counted == 10) || ($urandom_range(0, 39) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
               // ticks: mostly a slowly changing level pattern, sometimes noise
               it.cmd = CMD_TICK;
               r = $urandom_range(0, 99);
               if (r < 40) begin
                  flip = TABLE_PINS[$urandom_range(0, 15)];
                  if (flip < PIN_TOTAL)
                     lv_state[flip] = ~lv_state[flip];
               end else if (r < 43) begin
                  lv_state = LEVELS_W'({$urandom, $urandom});
               end
               if (r < 95)
                  it.levels = lv_state;
            end else if (sel < 75) begin
               it.cmd = CMD_SET_OUT;
               it.pin = ($urandom_range(0, 9) == 0) ? PIN_W'($urandom) :
                                                     PIN_W'(TABLE_PINS[$urandom_range(0, 15)]);
               r = $urandom_range(0, 9);
               if (r == 0)
                  it.interval = '0;
               else if (r != 1)
                  it.interval = $urandom_range(1, 8);
            end else if (sel < 85) begin
               it.cmd = CMD_SET_IN;
               it.pin = ($urandom_range(0, 9) == 0) ? PIN_W'($urandom) :
                                                     PIN_W'(TABLE_PINS[$urandom_range(0, 15)]);
            end else if (sel < 89) begin
               it.cmd = CMD_ALL_LOW;
            end else if (sel < 93) begin
               it.cmd = CMD_ALL_HIGH;
            end else begin
               it.cmd = CMD_SPARE_FIRST + CMD_W'($urandom_range(0, CMD_SPARE_LAST - CMD_SPARE_FIRST));
            end
            if (it.cmd <= CMD_ALL_HIGH)
               counted++;
            cmd_backlog.push_back(it);
         end
         wait_quiet();
      end

      $display("covered %0d command items in %0d debounce settings (0 to 65535), idling from none to 65 in 100",
               items_taken, PHASES + 1);
      $display("checked %0d results: %0d drives, %0d reverts, %0d presses, %0d failures",
               results_seen, drives_seen, reverts_seen, presses_seen, fail_count);
      if (fail_count == 0 && pin_events_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // hang guard
   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d results outstanding", pin_events_due.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
rtl/core/gpdt_pkg.sv
rtl/core/gpdt_ifs.sv
rtl/core/gpdt_front.sv
rtl/core/gpdt_back.sv
rtl/core/gpio_pulse_debounce_table_unit.sv
rtl/core/gpdt_checker.sv
bench/tb.sv
